[rtl/iis_pkg.sv]
// iis_pkg: shared types and constants for the integral image block
// register indexes, default parameter values and the per-pixel flag struct
// no dependencies
package iis_pkg;

  localparam int DefMaxWidth = 4096;
  localparam int DefSumBits  = 32;

  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 16;

  localparam logic [CfgIdxBits-1:0] REG_ROW_WIDTH    = 2'd0;
  localparam logic [CfgIdxBits-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CfgIdxBits-1:0] REG_WIDE_SUMS    = 2'd2;

  localparam logic [12:0] RowWidthReset    = 13'd640;
  localparam logic [15:0] FrameHeightReset = 16'd480;
  localparam logic        WideSumsReset    = 1'b1;

  typedef struct packed {
    logic row_first;
    logic row_end;
    logic frame_end;
  } iis_flags_t;

endpackage

[rtl/iis_ram.sv]
// iis_ram: generic single-clock ram, one write port, one read port
// read data registered, held while the read enable is low
// no dependencies
module iis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/iis_scan.sv]
// iis_scan: configuration registers, column and row counters, running row sum
// gives the column, new row sum and flags of the pixel being transferred
// depends on iis_pkg
module iis_scan #(
  parameter int MAX_WIDTH = iis_pkg::DefMaxWidth,
  parameter int SUM_BITS  = iis_pkg::DefSumBits
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [iis_pkg::CfgIdxBits-1:0]     cfg_index,
  input  logic [iis_pkg::CfgDataBits-1:0]    cfg_data,
  input  logic                               advance,
  input  logic [7:0]                         pixel,
  output logic [$clog2(MAX_WIDTH)-1:0]       col,
  output logic [SUM_BITS-1:0]                rsum_new,
  output iis_pkg::iis_flags_t                flags,
  output logic                               wide
);
  import iis_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;

  logic [12:0]         row_width;
  logic [15:0]         frame_height;
  logic [CW-1:0]       column_count;
  logic [15:0]         row_count;
  logic [SUM_BITS-1:0] running_row_sum;

  logic [WW-1:0] w_eff;
  logic [16:0]   h_eff;
  logic          last_col;
  logic          last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width    <= RowWidthReset;
      frame_height <= FrameHeightReset;
      wide         <= WideSumsReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROW_WIDTH:    row_width    <= cfg_data[12:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_WIDE_SUMS:    wide         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // zero width acts as one, oversize width saturates
    if (row_width == 13'd0) begin
      w_eff = WW'(1);
    end else if (32'(row_width) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(row_width);
    end
    h_eff    = (frame_height == 16'd0) ? 17'd1 : {1'b0, frame_height};
    last_col = ({1'b0, column_count} + WW'(1)) >= w_eff;
    last_row = ({1'b0, row_count} + 17'd1) >= h_eff;
  end

  assign col             = column_count;
  assign rsum_new        = running_row_sum + SUM_BITS'(pixel);
  assign flags.row_first = (row_count == 16'd0);
  assign flags.row_end   = last_col;
  assign flags.frame_end = last_col && last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      row_count       <= '0;
      running_row_sum <= '0;
    end else if (advance) begin
      if (last_col) begin
        column_count    <= '0;
        running_row_sum <= '0;
        row_count       <= last_row ? 16'd0 : row_count + 16'd1;
      end else begin
        column_count    <= column_count + CW'(1);
        running_row_sum <= rsum_new;
      end
    end
  end

endmodule

[rtl/integral_image_sum.sv]
// integral_image_sum: streaming summed-area table over 8-bit raster pixels
//
// channels: pixel in (in_valid/in_ready), one result per pixel out
// (out_valid/out_ready) carrying area_sum, row_end and frame_end, and a
// config write channel (cfg_valid/cfg_ready, cfg_index, cfg_data) for
// row_width (0), frame_height (1) and wide_sums (2); cfg_ready is always high.
// throughput: one pixel per clock while the receiver keeps out_ready high;
// each pixel passes the line store read stage, then the output register.
// the line store ram holds the previous row's sums; each pixel reads its
// column when it is taken and writes the new sum back when it moves to the
// output register; a write and a read of the same column in one cycle is
// forwarded. the first row of a frame uses zero in place of the store.
// reset clears counters, running sum and valid flags and loads the default
// registers; the line store needs no clearing.
// a stalled receiver holds the output register; one more pixel is taken into
// the read stage, then in_ready drops until the output drains.
// depends on iis_pkg, iis_scan, iis_ram
module integral_image_sum #(
  parameter int MAX_WIDTH = iis_pkg::DefMaxWidth,
  parameter int SUM_BITS  = iis_pkg::DefSumBits
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [iis_pkg::CfgIdxBits-1:0]  cfg_index,
  input  logic [iis_pkg::CfgDataBits-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      pixel,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [31:0]                     area_sum,
  output logic                            row_end,
  output logic                            frame_end
);
  import iis_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam logic [SUM_BITS-1:0] NarrowMask = SUM_BITS'(32'h0000_FFFF);

  logic                accept;
  logic [CW-1:0]       scan_col;
  logic [SUM_BITS-1:0] scan_rsum;
  iis_flags_t          scan_flags;
  logic                wide;

  logic                s1_valid;
  logic [CW-1:0]       s1_col;
  logic [SUM_BITS-1:0] s1_rsum;
  iis_flags_t          s1_flags;
  logic                s1_fwd;
  logic [SUM_BITS-1:0] s1_fwd_val;
  logic                s1_adv;

  logic [SUM_BITS-1:0] rd_data;
  logic [SUM_BITS-1:0] above;
  logic [SUM_BITS-1:0] val;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_adv;
  assign accept    = in_valid && in_ready;

  iis_scan #(
    .MAX_WIDTH(MAX_WIDTH),
    .SUM_BITS (SUM_BITS)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .advance  (accept),
    .pixel    (pixel),
    .col      (scan_col),
    .rsum_new (scan_rsum),
    .flags    (scan_flags),
    .wide     (wide)
  );

  iis_ram #(
    .WIDTH(SUM_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_line (
    .clk    (clk),
    .wr_en  (s1_adv),
    .wr_addr(s1_col),
    .wr_data(val),
    .rd_en  (accept),
    .rd_addr(scan_col),
    .rd_data(rd_data)
  );

  always_comb begin
    if (s1_flags.row_first) begin
      above = '0;
    end else if (s1_fwd) begin
      above = s1_fwd_val;
    end else begin
      above = rd_data;
    end
    val = s1_rsum + above;
    if (!wide) begin
      val = val & NarrowMask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col     <= scan_col;
      s1_rsum    <= scan_rsum;
      s1_flags   <= scan_flags;
      // ram returns old data when written and read at one address
      s1_fwd     <= s1_adv && (s1_col == scan_col);
      s1_fwd_val <= val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      area_sum  <= 32'(val);
      row_end   <= s1_flags.row_end;
      frame_end <= s1_flags.frame_end;
    end
  end

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("transferred pixel missing from read stage");

  a_stage_to_output: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("read stage result lost before output register");

  a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> row_end)
    else $error("frame end without row end");

  a_no_stall_drop: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_col)))
    else $error("stalled read stage changed");

endmodule

[tb/sv/tb.sv]
// tb: self-checking testbench for integral_image_sum
// holds its own summed-area predictor, drives pixels and register writes, checks every result
// depends on iis_pkg and the integral_image_sum rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iis_pkg::*;

  localparam int MaxWidth = DefMaxWidth;
  localparam logic [CfgIdxBits-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned QuietLimit = 400;
  localparam int unsigned LatencyTail = 8;
  localparam int unsigned RandomPixels = 560;

  typedef enum logic [1:0] {
    PIX_ANY,
    PIX_EXTREME,
    PIX_BRIGHT
  } pix_mode_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        row_end;
    logic        frame_end;
  } pixel_result_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CfgIdxBits-1:0]  cfg_index;
  logic [CfgDataBits-1:0] cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [7:0]             pixel;
  logic                   out_valid;
  logic                   out_ready;
  logic [31:0]            area_sum;
  logic                   row_end;
  logic                   frame_end;

  // predictor state
  logic [12:0]   cur_row_width;
  logic [15:0]   cur_frame_height;
  logic          cur_wide;
  logic [31:0]   line_sums [MaxWidth];
  logic [31:0]   row_run_sum;
  int unsigned   col_pos;
  int unsigned   row_pos;

  pixel_result_t expected_sums [$];
  int unsigned   mismatches;
  int unsigned   quiet_cycles;
  int unsigned   sink_hold;
  logic          src_idle_on;
  logic          sink_idle_on;

  integral_image_sum dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel     (pixel),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .area_sum  (area_sum),
    .row_end   (row_end),
    .frame_end (frame_end)
  );

  always #5 clk = ~clk;

  function automatic int unsigned clamp_width(input logic [12:0] w);
    if (w == 13'd0) return 1;
    if (w > MaxWidth) return MaxWidth;
    return w;
  endfunction

  function automatic int unsigned clamp_height(input logic [15:0] h);
    return (h == 16'd0) ? 1 : h;
  endfunction

  function automatic pixel_result_t integrate_pixel(input logic [7:0] value);
    int unsigned   w;
    int unsigned   h;
    logic [31:0]   above;
    pixel_result_t r;
    w = clamp_width(cur_row_width);
    h = clamp_height(cur_frame_height);
    row_run_sum = row_run_sum + 32'(value);
    // the first row of a frame sees zero above it
    above = (row_pos == 0) ? 32'd0 : line_sums[col_pos];
    r.sum = row_run_sum + above;
    if (!cur_wide) r.sum[31:16] = 16'd0;
    line_sums[col_pos] = r.sum;
    r.row_end = (col_pos + 1 >= w);
    r.frame_end = r.row_end && (row_pos + 1 >= h);
    if (r.row_end) begin
      col_pos = 0;
      row_run_sum = '0;
      row_pos = r.frame_end ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return r;
  endfunction

  function automatic int unsigned pixels_to_frame_end();
    int unsigned w;
    int unsigned h;
    int unsigned rows_left;
    int unsigned in_row;
    w = clamp_width(cur_row_width);
    h = clamp_height(cur_frame_height);
    rows_left = (row_pos + 1 >= h) ? 0 : h - row_pos - 1;
    in_row = (col_pos + 1 >= w) ? 1 : w - col_pos;
    return rows_left * w + in_row;
  endfunction

  function automatic int unsigned idle_cycles(input logic enabled);
    return enabled ? $urandom_range(0, 16) : 0;
  endfunction

  function automatic logic [7:0] draw_pixel(input pix_mode_t mode);
    case (mode)
      PIX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      PIX_BRIGHT:  return 8'($urandom_range(200, 255));
      default:     return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic log_mismatch(input string what, input logic [31:0] want,
                              input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s expected %0h got %0h", $time, what, want, got);
  endtask

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(input logic [CfgIdxBits-1:0] idx,
                           input logic [CfgDataBits-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ROW_WIDTH:    cur_row_width = data[12:0];
      REG_FRAME_HEIGHT: cur_frame_height = data;
      REG_WIDE_SUMS:    cur_wide = data[0];
      default: ;
    endcase
  endtask

  // leaves in_valid high so back-to-back pixels need no extra edge
  task automatic send_pixel(input logic [7:0] value);
    int unsigned gap;
    gap = idle_cycles(src_idle_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel    <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_sums.push_back(integrate_pixel(value));
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    wait_results();
  endtask

  // width cut below the current column ends the row at once, zero height acts as one
  task automatic test_row_cut();
    write_reg(REG_ROW_WIDTH, 16'hE002);
    write_reg(REG_FRAME_HEIGHT, 16'h0000);
    cfg_valid <= 1'b0;
    send_pixel(8'h80);
    wait_results();
  endtask

  task automatic test_single_column();
    write_reg(REG_ROW_WIDTH, 16'h0000);
    write_reg(REG_FRAME_HEIGHT, 16'd3);
    cfg_valid <= 1'b0;
    send_pixel(8'h01);
    send_pixel(8'h02);
    send_pixel(8'h04);
    send_pixel(8'h08);
    wait_results();
  endtask

  // second row of a frame, height cut below it: frame ends with this row
  task automatic test_height_cut();
    write_reg(REG_FRAME_HEIGHT, 16'd1);
    cfg_valid <= 1'b0;
    send_pixel(8'h10);
    wait_results();
  endtask

  task automatic test_max_registers();
    write_reg(REG_ROW_WIDTH, 16'h1FFF);
    write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
    write_reg(REG_UNUSED, 16'h0005);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 6; i++) send_pixel((i % 2) ? 8'h00 : 8'hFF);
    wait_results();
    write_reg(REG_ROW_WIDTH, 16'd3);
    cfg_valid <= 1'b0;
    send_pixel(8'h7F);
    for (int i = 0; i < 3; i++) send_pixel(8'($urandom_range(0, 255)));
    wait_results();
    write_reg(REG_FRAME_HEIGHT, 16'd2);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 3; i++) send_pixel(8'($urandom_range(0, 255)));
    wait_results();
  endtask

  // 12x24 bright frame: last rows pass 2^16 in wide mode, then wrap in narrow mode
  task automatic test_sum_width();
    write_reg(REG_ROW_WIDTH, 16'd12);
    write_reg(REG_FRAME_HEIGHT, 16'd24);
    write_reg(REG_WIDE_SUMS, 16'hFFFF);
    cfg_valid <= 1'b0;
    repeat (276) send_pixel(8'($urandom_range(248, 255)));
    wait_results();
    write_reg(REG_WIDE_SUMS, 16'h0000);
    cfg_valid <= 1'b0;
    repeat (12) send_pixel(8'($urandom_range(248, 255)));
    wait_results();
  endtask

  task automatic test_random_frames();
    int unsigned sent;
    int unsigned n;
    int unsigned w_new;
    int unsigned to_end;
    int unsigned pick;
    pix_mode_t   mode;
    sent = 0;
    while (sent < RandomPixels) begin
      src_idle_on  = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1)) begin
        pick = $urandom_range(0, 15);
        if (pick == 0) w_new = 0;
        else if (pick == 1) w_new = $urandom_range(100, 8191);
        else if (pick < 6) w_new = $urandom_range(13, 40);
        else w_new = $urandom_range(1, 12);
        // widening is only safe at the start of a frame, the line store is not filled yet
        if (!(row_pos == 0 && col_pos == 0) &&
            clamp_width(13'(w_new)) > clamp_width(cur_row_width))
          w_new = $urandom_range(0, clamp_width(cur_row_width));
        write_reg(REG_ROW_WIDTH, {3'($urandom_range(0, 7)), 13'(w_new)});
      end
      if ($urandom_range(0, 1)) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) write_reg(REG_FRAME_HEIGHT, 16'd0);
        else if (pick == 1) write_reg(REG_FRAME_HEIGHT, 16'($urandom_range(0, 65535)));
        else write_reg(REG_FRAME_HEIGHT, 16'($urandom_range(1, 6)));
      end
      if ($urandom_range(0, 2) == 0)
        write_reg(REG_WIDE_SUMS, 16'($urandom_range(0, 65535)));
      cfg_valid <= 1'b0;
      pick = $urandom_range(0, 3);
      mode = (pick == 0) ? PIX_EXTREME : (pick == 1) ? PIX_BRIGHT : PIX_ANY;
      to_end = pixels_to_frame_end();
      n = ($urandom_range(0, 2) != 0 && to_end <= 150) ? to_end : $urandom_range(1, 40);
      repeat (n) send_pixel(draw_pixel(mode));
      sent += n;
      wait_results();
    end
  endtask

  // result check
  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_sums.size() == 0) begin
        log_mismatch("result with none pending, area_sum", '0, area_sum);
      end else begin
        want = expected_sums.pop_front();
        if (area_sum !== want.sum) log_mismatch("area_sum", want.sum, area_sum);
        if (row_end !== want.row_end) log_mismatch("row_end", want.row_end, row_end);
        if (frame_end !== want.frame_end)
          log_mismatch("frame_end", want.frame_end, frame_end);
      end
    end
  end

  // receiver stall, drawn after every transfer
  always @(posedge clk) begin
    if (out_valid && out_ready) sink_hold = idle_cycles(sink_idle_on);
    if (sink_hold > 0) begin
      out_ready <= 1'b0;
      sink_hold--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    pixel = 8'h00;
    cfg_valid = 1'b0;
    cfg_index = REG_ROW_WIDTH;
    cfg_data = '0;
    out_ready = 1'b0;
    sink_hold = 0;
    quiet_cycles = 0;
    mismatches = 0;
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    cur_row_width = RowWidthReset;
    cur_frame_height = FrameHeightReset;
    cur_wide = WideSumsReset;
    row_run_sum = '0;
    col_pos = 0;
    row_pos = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_row_cut();
    test_single_column();
    test_height_cut();
    test_max_registers();
    test_sum_width();
    test_random_frames();

    wait_results();
    repeat (LatencyTail) @(posedge clk);
    if (expected_sums.size() != 0)
      log_mismatch("results never seen, count", '0, expected_sums.size());
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/iis_pkg.sv
rtl/iis_ram.sv
rtl/iis_scan.sv
rtl/integral_image_sum.sv
tb/sv/tb.sv
